@@ src/hblt_pkg.sv @@
// Shared types and constants of the heartbeat liveness table.
// Used by the table memory and by the core; depends on nothing else.
package hblt_pkg;

  localparam int unsigned TableEntriesDef = 64;
  localparam logic [7:0]  TimeoutReset    = 8'd15;
  localparam logic [7:0]  PeriodReset     = 8'd15;

  // Action codes of an input transaction.
  localparam logic [1:0] ActHeartbeat = 2'd0;
  localparam logic [1:0] ActTick      = 2'd1;
  localparam logic [1:0] ActList      = 2'd2;

  // Configuration register indexes.
  localparam logic CfgTimeout = 1'b0;
  localparam logic CfgPeriod  = 1'b1;

  typedef enum logic [2:0] {
    StUpdated = 3'd0,
    StAdded   = 3'd1,
    StFull    = 3'd2,
    StTick    = 3'd3,
    StEntry   = 3'd4,
    StNone    = 3'd5
  } status_e;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic [31:0] address;
    logic [15:0] port;
    logic [15:0] load;
    logic [31:0] stamp;
    logic        active;
  } entry_t;

endpackage

@@ src/heartbeat_liveness_table_core.sv @@
// Heartbeat liveness table: node table in a synchronous memory, scanned by a
// read-modify-write engine. Depends on hblt_pkg and hblt_ram.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one action per transaction:
//   heartbeat, one-second tick, or list. Output channel (out_valid_o/
//   out_ready_i) returns one result per heartbeat and tick, and one result
//   per active entry for a list (StNone when there is none); is_last_o
//   marks the final result of each input transaction.
//   Items are processed one at a time. A heartbeat walks the used entries at
//   one entry per cycle through the memory read port until it finds its key.
//   A tick walks the used entries only when it triggers a sweep. A list walks
//   the used entries too, pausing while the receiver stalls. Scan speed is
//   set by the single memory read port.
//   Results leave through an output register, so a new input transaction is
//   taken while the last result still waits. A stalled receiver pauses a list
//   scan in place; nothing is dropped.
//   Reset empties the table (fill count zero), clears the tick counter and
//   sweep countdown and loads both configuration registers with 15. No
//   memory clearing pass is needed. Configuration writes take effect at once.
module heartbeat_liveness_table_core #(
  parameter int unsigned TABLE_ENTRIES = hblt_pkg::TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] node_address_i,
  input  logic [15:0] node_port_i,
  input  logic [15:0] load_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] out_address_o,
  output logic [15:0] out_port_o,
  output logic [15:0] out_load_o,
  output logic [31:0] out_last_seen_o,
  output logic        is_last_o
);
  import hblt_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [CntW-1:0] Full = CntW'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    ScIdle,
    ScScan,
    ScFin
  } state_e;

  state_e          state_q, state_d;
  logic [1:0]      op_q, op_d;
  logic [31:0]     in_addr_q, in_addr_d;
  logic [15:0]     in_port_q, in_port_d;
  logic [15:0]     in_load_q, in_load_d;
  logic [7:0]      timeout_q, timeout_d;
  logic [7:0]      period_q, period_d;
  logic [CntW-1:0] used_q, used_d;
  logic [31:0]     now_q, now_d;
  logic [7:0]      cd_q, cd_d;
  logic [CntW-1:0] iss_q, iss_d;
  logic [IdxW-1:0] tag_q, tag_d;
  logic            rv_q, rv_d;
  logic            hold_vld_q, hold_vld_d;
  entry_t          hold_q, hold_d;
  status_e         res_q, res_d;
  logic            out_valid_q, out_valid_d;
  status_e         out_status_q, out_status_d;
  entry_t          out_ent_q, out_ent_d;
  logic            out_last_q, out_last_d;

  logic            ram_re, ram_we;
  logic [IdxW-1:0] ram_raddr, ram_waddr;
  entry_t          ram_wdata, rd;

  logic            out_free, more, match, stale, stall, hit, consume, issue;
  logic [31:0]     age;
  logic [8:0]      cd_inc;

  hblt_ram #(
    .Depth(TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign more     = iss_q < used_q;
  assign match    = (rd.address == in_addr_q) && (rd.port == in_port_q);
  assign age      = now_q - rd.stamp;
  assign stale    = rd.active && (age > {24'd0, timeout_q});
  // A list scan may only consume an active entry if the previous one can leave.
  assign stall    = (op_q == ActList) && rv_q && rd.active && hold_vld_q && !out_free;
  assign hit      = (op_q == ActHeartbeat) && rv_q && match;
  assign consume  = rv_q && !stall;
  assign issue    = (state_q == ScScan) && more && !stall && !hit;
  assign cd_inc   = {1'b0, cd_q} + 9'd1;
  assign in_ready_o = (state_q == ScIdle);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    in_addr_d    = in_addr_q;
    in_port_d    = in_port_q;
    in_load_d    = in_load_q;
    timeout_d    = timeout_q;
    period_d     = period_q;
    used_d       = used_q;
    now_d        = now_q;
    cd_d         = cd_q;
    iss_d        = iss_q;
    tag_d        = tag_q;
    rv_d         = rv_q;
    hold_vld_d   = hold_vld_q;
    hold_d       = hold_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_ent_d    = out_ent_q;
    out_last_d   = out_last_q;
    ram_re       = 1'b0;
    ram_raddr    = iss_q[IdxW-1:0];
    ram_we       = 1'b0;
    ram_waddr    = tag_q;
    ram_wdata    = rd;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgTimeout: timeout_d = cfg_data_i;
        CfgPeriod:  period_d  = cfg_data_i;
        default:    ;
      endcase
    end

    unique case (state_q)
      ScIdle: begin
        if (in_valid_i) begin
          op_d       = action_i;
          in_addr_d  = node_address_i;
          in_port_d  = node_port_i;
          in_load_d  = load_i;
          iss_d      = '0;
          rv_d       = 1'b0;
          hold_vld_d = 1'b0;
          case (action_i)
            ActHeartbeat, ActList: state_d = ScScan;
            ActTick: begin
              now_d = now_q + 32'd1;
              res_d = StTick;
              if (cd_inc >= {1'b0, period_q}) begin
                cd_d    = '0;
                state_d = ScScan;
              end else begin
                cd_d    = cd_inc[7:0];
                state_d = ScFin;
              end
            end
            default: ;
          endcase
        end
      end

      ScScan: begin
        if (consume) begin
          case (op_q)
            ActHeartbeat: begin
              if (match) begin
                ram_we           = 1'b1;
                ram_wdata.load   = in_load_q;
                ram_wdata.stamp  = now_q;
                ram_wdata.active = 1'b1;
                res_d            = StUpdated;
                state_d          = ScFin;
              end
            end
            ActTick: begin
              if (stale) begin
                ram_we           = 1'b1;
                ram_wdata.active = 1'b0;
              end
            end
            default: begin
              if (rd.active) begin
                // The held entry is not the last one: another active one follows.
                if (hold_vld_q) begin
                  out_valid_d  = 1'b1;
                  out_status_d = StEntry;
                  out_ent_d    = hold_q;
                  out_last_d   = 1'b0;
                end
                hold_d     = rd;
                hold_vld_d = 1'b1;
              end
            end
          endcase
        end

        if (issue) begin
          ram_re = 1'b1;
          tag_d  = iss_q[IdxW-1:0];
          iss_d  = iss_q + 1'b1;
        end
        rv_d = issue || (rv_q && !consume);

        if (!more && (!rv_q || consume) && !hit) begin
          state_d = ScFin;
          case (op_q)
            ActHeartbeat: begin
              if (used_q < Full) begin
                ram_we    = 1'b1;
                ram_waddr = used_q[IdxW-1:0];
                ram_wdata = '{address: in_addr_q, port: in_port_q, load: in_load_q,
                              stamp: now_q, active: 1'b1};
                used_d    = used_q + 1'b1;
                res_d     = StAdded;
              end else begin
                res_d = StFull;
              end
            end
            ActTick: res_d = StTick;
            default: res_d = hold_vld_d ? StEntry : StNone;
          endcase
        end
      end

      ScFin: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_q;
          out_ent_d    = (res_q == StEntry) ? hold_q : '0;
          out_last_d   = 1'b1;
          state_d      = ScIdle;
        end
      end

      default: state_d = ScIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ScIdle;
      op_q         <= ActHeartbeat;
      in_addr_q    <= '0;
      in_port_q    <= '0;
      in_load_q    <= '0;
      timeout_q    <= TimeoutReset;
      period_q     <= PeriodReset;
      used_q       <= '0;
      now_q        <= '0;
      cd_q         <= '0;
      iss_q        <= '0;
      tag_q        <= '0;
      rv_q         <= 1'b0;
      hold_vld_q   <= 1'b0;
      hold_q       <= '0;
      res_q        <= StUpdated;
      out_valid_q  <= 1'b0;
      out_status_q <= StUpdated;
      out_ent_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      in_addr_q    <= in_addr_d;
      in_port_q    <= in_port_d;
      in_load_q    <= in_load_d;
      timeout_q    <= timeout_d;
      period_q     <= period_d;
      used_q       <= used_d;
      now_q        <= now_d;
      cd_q         <= cd_d;
      iss_q        <= iss_d;
      tag_q        <= tag_d;
      rv_q         <= rv_d;
      hold_vld_q   <= hold_vld_d;
      hold_q       <= hold_d;
      res_q        <= res_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_ent_q    <= out_ent_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign out_address_o   = out_ent_q.address;
  assign out_port_o      = out_ent_q.port;
  assign out_load_o      = out_ent_q.load;
  assign out_last_seen_o = out_ent_q.stamp;
  assign is_last_o       = out_last_q;

  // A write-back never lands on the entry being read in the same cycle.
  a_no_rw_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("table write and read hit the same entry");

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= Full)
    else $error("fill count exceeds table size");

  // The table only grows, one entry per appending heartbeat.
  a_used_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> (used_q == $past(used_q) + 1'b1))
    else $error("fill count changed by other than one");

  // An intermediate list result is only produced while a scan is running.
  a_list_mid_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && !out_last_d && !(out_valid_q && !out_ready_i)) |-> (state_q == ScScan))
    else $error("non-final result outside a list scan");

endmodule

@@ src/hblt_ram.sv @@
// Single-port-write, single-port-read table memory with registered read data.
// Depends on hblt_pkg for the entry layout.
module hblt_ram #(
  parameter int unsigned Depth = hblt_pkg::TableEntriesDef,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output hblt_pkg::entry_t     rdata_o,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  hblt_pkg::entry_t     wdata_i
);
  import hblt_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Read data holds while no read is issued, so a stalled consumer keeps it.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
